// ----- src/chi_pkg.sv -----
// shared types, constants and hash functions of the chained hash index
`default_nettype none

package chi_pkg;

    // default sizing of the index
    localparam int BUCKETS_DEF     = 1024;
    localparam int POOL_NODES_DEF  = 1024;
    localparam int MAX_CHAIN_DEF   = 64;
    localparam int RECORD_BITS_DEF = 20;

    // fixed port field widths
    localparam int OP_W        = 1;
    localparam int BYTE_W      = 8;
    localparam int REC_PORT_W  = 20;
    localparam int STATUS_W    = 2;
    localparam int BKT_PORT_W  = 10;
    localparam int HASH_W      = 32;

    // remainder unit: hash bits consumed per step and steps per key
    localparam int MOD_BITS_PER_STEP = 4;
    localparam int MOD_STEPS         = HASH_W / MOD_BITS_PER_STEP;
    localparam int MOD_CNT_W         = $clog2(MOD_STEPS);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_ENTRY    = 2'd1,
        ST_NONE     = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FINISH,
        S_MOD,
        S_BKT_RD,
        S_DECIDE,
        S_NODE_RD,
        S_NODE_EMIT
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    clear_step;
        logic    hash_fold;
        logic    hash_finish;
        logic    mod_step;
        logic    insert_commit;
        logic    walk_load;
        logic    walk_step;
        logic    out_load;
        status_t out_code;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic mod_done;
        logic is_lookup;
        logic bucket_hit;
        logic insert_full;
        logic walk_last;
        logic out_free;
    } dp_stat_t;

    // one-at-a-time hash, per byte
    function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] t;
        t = h + HASH_W'(b);
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    // one-at-a-time hash, final avalanche
    function automatic logic [HASH_W-1:0] finish_hash(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- src/chi_in_if.sv -----
// request channel: key bytes with operation and record number
`default_nettype none

interface chi_in_if;
    logic                               valid;
    logic                               ready;
    logic [chi_pkg::OP_W-1:0]           operation;
    logic [chi_pkg::BYTE_W-1:0]         key_byte;
    logic                               key_last;
    logic [chi_pkg::REC_PORT_W-1:0]     record_index;

    modport source (output valid, operation, key_byte, key_last, record_index,
                    input ready);
    modport sink   (input valid, operation, key_byte, key_last, record_index,
                    output ready);
endinterface

`default_nettype wire

// ----- src/chi_out_if.sv -----
// response channel: one beat per result
`default_nettype none

interface chi_out_if;
    logic                               valid;
    logic                               ready;
    logic [chi_pkg::STATUS_W-1:0]       status;
    logic [chi_pkg::REC_PORT_W-1:0]     found_record;
    logic [chi_pkg::BKT_PORT_W-1:0]     bucket_number;
    logic                               last_result;

    modport source (output valid, status, found_record, bucket_number, last_result,
                    input ready);
    modport sink   (input valid, status, found_record, bucket_number, last_result,
                    output ready);
endinterface

`default_nettype wire

// ----- src/chi_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module chi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/chi_ctrl.sv -----
// controller state machine of the chained hash index
`default_nettype none

module chi_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              key_last,
    output logic                   req_ready,
    input  wire chi_pkg::dp_stat_t stat,
    output chi_pkg::dp_cmd_t       cmd
);

    chi_pkg::ctrl_state_t state_reg;
    chi_pkg::ctrl_state_t state_next;
    logic                 accept;

    assign accept = req_valid && req_ready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chi_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chi_pkg::S_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = chi_pkg::S_IDLE;
                end
            end
            chi_pkg::S_IDLE:
            begin
                if (accept && key_last)
                begin
                    state_next = chi_pkg::S_FINISH;
                end
            end
            chi_pkg::S_FINISH:
            begin
                state_next = chi_pkg::S_MOD;
            end
            chi_pkg::S_MOD:
            begin
                if (stat.mod_done)
                begin
                    state_next = chi_pkg::S_BKT_RD;
                end
            end
            chi_pkg::S_BKT_RD:
            begin
                state_next = chi_pkg::S_DECIDE;
            end
            chi_pkg::S_DECIDE:
            begin
                if (stat.is_lookup && stat.bucket_hit)
                begin
                    state_next = chi_pkg::S_NODE_RD;
                end
                else if (stat.out_free)
                begin
                    state_next = chi_pkg::S_IDLE;
                end
            end
            chi_pkg::S_NODE_RD:
            begin
                state_next = chi_pkg::S_NODE_EMIT;
            end
            chi_pkg::S_NODE_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.walk_last ? chi_pkg::S_IDLE : chi_pkg::S_NODE_RD;
                end
            end
            default:
            begin
                state_next = chi_pkg::S_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready         = 1'b0;
        cmd               = '0;
        cmd.out_code      = chi_pkg::ST_INSERTED;
        case (state_reg)
            chi_pkg::S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            chi_pkg::S_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.hash_fold = accept;
            end
            chi_pkg::S_FINISH:
            begin
                cmd.hash_finish = 1'b1;
            end
            chi_pkg::S_MOD:
            begin
                cmd.mod_step = 1'b1;
            end
            chi_pkg::S_DECIDE:
            begin
                if (stat.is_lookup)
                begin
                    if (stat.bucket_hit)
                    begin
                        cmd.walk_load = 1'b1;
                    end
                    else if (stat.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_code = chi_pkg::ST_NONE;
                    end
                end
                else if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.insert_full)
                    begin
                        cmd.out_code = chi_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.insert_commit = 1'b1;
                        cmd.out_code      = chi_pkg::ST_INSERTED;
                    end
                end
            end
            chi_pkg::S_NODE_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_code  = chi_pkg::ST_ENTRY;
                    cmd.walk_step = 1'b1;
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/chi_dp.sv -----
// datapath: hash, bucket remainder, bucket and node tables, chain walk, result register
`default_nettype none

module chi_dp #(
    parameter int BUCKETS     = chi_pkg::BUCKETS_DEF,
    parameter int POOL_NODES  = chi_pkg::POOL_NODES_DEF,
    parameter int MAX_CHAIN   = chi_pkg::MAX_CHAIN_DEF,
    parameter int RECORD_BITS = chi_pkg::RECORD_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire chi_pkg::dp_cmd_t                   cmd,
    output chi_pkg::dp_stat_t                       stat,
    input  wire logic [chi_pkg::OP_W-1:0]           operation,
    input  wire logic [chi_pkg::BYTE_W-1:0]         key_byte,
    input  wire logic [chi_pkg::REC_PORT_W-1:0]     record_index,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic [chi_pkg::STATUS_W-1:0]            status,
    output logic [chi_pkg::REC_PORT_W-1:0]          found_record,
    output logic [chi_pkg::BKT_PORT_W-1:0]          bucket_number,
    output logic                                    last_result
);

    localparam int BW    = $clog2(BUCKETS);
    localparam int BW1   = BW + 1;
    localparam int NW    = $clog2(POOL_NODES);
    localparam int NU_W  = $clog2(POOL_NODES + 1);
    localparam int LW    = $clog2(MAX_CHAIN + 1);
    localparam int REC_W = (RECORD_BITS < chi_pkg::REC_PORT_W) ? RECORD_BITS
                                                                : chi_pkg::REC_PORT_W;
    localparam int BKT_W = 1 + 2 * NW + LW;
    localparam bit POW2  = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam int HW    = chi_pkg::HASH_W;
    localparam int MCW   = chi_pkg::MOD_CNT_W;

    // hash and remainder state
    logic [HW-1:0]       hash_reg, hash_next;
    logic [MCW-1:0]      mod_cnt_reg, mod_cnt_next;
    logic [BW-1:0]       rem_reg, rem_next;
    logic [BW-1:0]       rem_step;
    logic                mod_done;

    // operation latched from the key beats
    chi_pkg::op_t        op_reg;
    logic [REC_W-1:0]    rec_reg;

    // pool and clear sweep
    logic [NU_W-1:0]     nodes_used_reg, nodes_used_next;
    logic [BW-1:0]       clr_cnt_reg, clr_cnt_next;

    // chain walk
    logic [NW-1:0]       node_reg, node_next;
    logic [LW-1:0]       remain_reg, remain_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    chi_pkg::status_t    out_status_reg;
    logic [REC_W-1:0]    out_record_reg;
    logic [BW-1:0]       out_bucket_reg;
    logic                out_last_reg;

    // table ports
    logic                bkt_we;
    logic [BW-1:0]       bkt_waddr;
    logic [BKT_W-1:0]    bkt_wdata, bkt_rdata;
    logic                bkt_valid;
    logic [NW-1:0]       bkt_head, bkt_tail;
    logic [LW-1:0]       bkt_len;
    logic [NW-1:0]       node_new;
    logic [REC_W-1:0]    rec_rdata;
    logic [NW-1:0]       next_rdata;
    logic                insert_full;
    logic                out_free;

    // bucket word fields
    assign bkt_valid = bkt_rdata[BKT_W-1];
    assign bkt_head  = bkt_rdata[2*NW+LW-1 -: NW];
    assign bkt_tail  = bkt_rdata[NW+LW-1 -: NW];
    assign bkt_len   = bkt_rdata[LW-1:0];
    assign node_new  = nodes_used_reg[NW-1:0];

    assign insert_full = (nodes_used_reg >= NU_W'(POOL_NODES))
                      || (bkt_valid && (bkt_len >= LW'(MAX_CHAIN)));
    assign out_free    = !out_valid_reg || out_ready;
    assign mod_done    = POW2 || (mod_cnt_reg == MCW'(chi_pkg::MOD_STEPS - 1));

    // remainder step: a few hash bits msb first, compare and subtract each
    always_comb
    begin
        logic [BW1-1:0] t;
        logic [BW-1:0]  r;
        r = rem_reg;
        t = '0;
        for (int i = 0; i < chi_pkg::MOD_BITS_PER_STEP; i++)
        begin
            t = {r, hash_reg[HW-1-i]};
            if (t >= BW1'(BUCKETS))
            begin
                t = t - BW1'(BUCKETS);
            end
            r = t[BW-1:0];
        end
        rem_step = r;
    end

    // hash, remainder and sweep next values
    always_comb
    begin
        hash_next    = hash_reg;
        mod_cnt_next = mod_cnt_reg;
        rem_next     = rem_reg;
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear_step)
        begin
            clr_cnt_next = clr_cnt_reg + BW'(1);
        end
        if (cmd.hash_fold)
        begin
            hash_next = chi_pkg::fold_byte(hash_reg, key_byte);
        end
        if (cmd.hash_finish)
        begin
            hash_next    = chi_pkg::finish_hash(hash_reg);
            mod_cnt_next = '0;
            rem_next     = '0;
        end
        if (cmd.mod_step)
        begin
            mod_cnt_next = mod_cnt_reg + MCW'(1);
            if (POW2)
            begin
                rem_next = hash_reg[BW-1:0];
            end
            else
            begin
                rem_next = rem_step;
            end
            hash_next = mod_done ? '0 : (hash_reg << chi_pkg::MOD_BITS_PER_STEP);
        end
    end

    // pool count and chain walk next values
    always_comb
    begin
        nodes_used_next = nodes_used_reg;
        node_next       = node_reg;
        remain_next     = remain_reg;
        if (cmd.insert_commit)
        begin
            nodes_used_next = nodes_used_reg + NU_W'(1);
        end
        if (cmd.walk_load)
        begin
            node_next   = bkt_head;
            remain_next = bkt_len;
        end
        if (cmd.walk_step)
        begin
            node_next   = next_rdata;
            remain_next = remain_reg - LW'(1);
        end
    end

    // bucket table write: zero during the sweep, updated word on insert
    always_comb
    begin
        bkt_we    = cmd.clear_step || cmd.insert_commit;
        bkt_waddr = cmd.clear_step ? clr_cnt_reg : rem_reg;
        if (cmd.clear_step)
        begin
            bkt_wdata = '0;
        end
        else if (bkt_valid)
        begin
            bkt_wdata = {1'b1, bkt_head, node_new, bkt_len + LW'(1)};
        end
        else
        begin
            bkt_wdata = {1'b1, node_new, node_new, LW'(1)};
        end
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg       <= '0;
            mod_cnt_reg    <= '0;
            nodes_used_reg <= '0;
            clr_cnt_reg    <= '0;
            remain_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hash_reg       <= hash_next;
            mod_cnt_reg    <= mod_cnt_next;
            nodes_used_reg <= nodes_used_next;
            clr_cnt_reg    <= clr_cnt_next;
            remain_reg     <= remain_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        node_reg <= node_next;
        if (cmd.hash_fold)
        begin
            op_reg  <= chi_pkg::op_t'(operation);
            rec_reg <= record_index[REC_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_code;
            out_bucket_reg <= rem_reg;
            out_record_reg <= (cmd.out_code == chi_pkg::ST_ENTRY) ? rec_rdata : '0;
            out_last_reg   <= (cmd.out_code != chi_pkg::ST_ENTRY) || (remain_reg == LW'(1));
        end
    end

    // per bucket: valid, head, tail, length
    chi_ram #(
        .WIDTH (BKT_W),
        .DEPTH (BUCKETS)
    ) u_bkt_ram (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (rem_reg),
        .rdata (bkt_rdata)
    );

    // per node: stored record
    chi_ram #(
        .WIDTH (REC_W),
        .DEPTH (POOL_NODES)
    ) u_rec_ram (
        .clk   (clk),
        .we    (cmd.insert_commit),
        .waddr (node_new),
        .wdata (rec_reg),
        .raddr (node_reg),
        .rdata (rec_rdata)
    );

    // per node: link to the next node; the old tail gets linked on append
    chi_ram #(
        .WIDTH (NW),
        .DEPTH (POOL_NODES)
    ) u_next_ram (
        .clk   (clk),
        .we    (cmd.insert_commit && bkt_valid),
        .waddr (bkt_tail),
        .wdata (node_new),
        .raddr (node_reg),
        .rdata (next_rdata)
    );

    // status to the controller
    always_comb
    begin
        stat.clear_done  = clr_cnt_reg == BW'(BUCKETS - 1);
        stat.mod_done    = mod_done;
        stat.is_lookup   = op_reg == chi_pkg::OP_LOOKUP;
        stat.bucket_hit  = bkt_valid;
        stat.insert_full = insert_full;
        stat.walk_last   = remain_reg == LW'(1);
        stat.out_free    = out_free;
    end

    // result beat
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign found_record  = chi_pkg::REC_PORT_W'(out_record_reg);
    assign bucket_number = chi_pkg::BKT_PORT_W'(out_bucket_reg);
    assign last_result   = out_last_reg;

    // a result is only loaded into a free result register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded over a pending beat");

    // an insert is committed only when pool and chain have room
    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert_commit |-> !insert_full)
        else $error("insert committed into a full pool or chain");

    // the walk never steps past the chain length
    a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> remain_reg != '0)
        else $error("chain walk stepped with no entries left");

    // the hash restarts from zero once the bucket is known
    a_hash_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mod_step && mod_done |=> hash_reg == '0)
        else $error("hash not cleared after the key");

endmodule

`default_nettype wire

// ----- src/chained_hash_index.sv -----
// top level of the chained hash index
//
// Hash index from key strings to record numbers. Each request beat carries one key byte;
// a beat without key_last gives no response. On the beat with key_last the operation
// runs: the hash is finished, the bucket remainder is taken straight from the low hash
// bits when BUCKETS is a power of two and is otherwise worked out stepwise (four hash
// bits per cycle), the bucket table is read and the result is decided. An insert or a
// refusal then gives one response beat; a lookup gives one beat per chain entry, each
// after a node table read and then a result load, or one beat when the bucket is empty.
// The node walk, one registered table read per entry, sets the lookup rate. A finished
// result waits in an output register while the next key bytes are taken. After reset
// a clearing pass over every bucket empties the bucket table; no request is taken
// until it ends.
`default_nettype none

module chained_hash_index #(
    parameter int BUCKETS     = chi_pkg::BUCKETS_DEF,
    parameter int POOL_NODES  = chi_pkg::POOL_NODES_DEF,
    parameter int MAX_CHAIN   = chi_pkg::MAX_CHAIN_DEF,
    parameter int RECORD_BITS = chi_pkg::RECORD_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    chi_in_if.sink     req,
    chi_out_if.source  rsp
);

    chi_pkg::dp_cmd_t  cmd;
    chi_pkg::dp_stat_t stat;
    logic              req_ready;

    assign req.ready = req_ready;

    // sequencing
    chi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .key_last  (req.key_last),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // hash, tables and result register
    chi_dp #(
        .BUCKETS     (BUCKETS),
        .POOL_NODES  (POOL_NODES),
        .MAX_CHAIN   (MAX_CHAIN),
        .RECORD_BITS (RECORD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (req.operation),
        .key_byte      (req.key_byte),
        .record_index  (req.record_index),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .status        (rsp.status),
        .found_record  (rsp.found_record),
        .bucket_number (rsp.bucket_number),
        .last_result   (rsp.last_result)
    );

endmodule

`default_nettype wire
